// File: hdl/nnt_pkg.sv
// Shared types and constants of the nearest-neighbor tour builder.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps
`default_nettype none
package nnt_pkg;

    localparam int MAX_POINTS_DEF = 32;
    localparam int MAX_DIMS_DEF   = 8;

    localparam int COORD_W = 16;
    localparam int NODE_W  = 6;
    localparam int DIMS_W  = 4;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_XFER,
        ST_START,
        ST_ACC,
        ST_SCAN,
        ST_EMIT,
        ST_END
    } nnt_state_t;

    typedef struct packed {
        logic                      wr_en;
        logic [NODE_W-1:0]         wr_pt;
        logic [DIMS_W-1:0]         wr_dim;
        logic signed [COORD_W-1:0] wr_data;
        logic                      rot;
        logic                      acc_clr;
        logic                      acc_en;
        logic                      vis_init;
        logic                      vis_set;
        logic [NODE_W-1:0]         sel_node;
        logic [NODE_W-1:0]         n_pts;
        logic [DIMS_W-1:0]         dims;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/nnt_if.sv
// Valid/ready channel interfaces: coordinate beats in, tour node beats out.
// Depends on nnt_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface coord_if;
    logic                              valid;
    logic                              ready;
    logic signed [nnt_pkg::COORD_W-1:0] coord;
    logic                              last;

    modport source (output valid, output coord, output last, input ready);
    modport sink (input valid, input coord, input last, output ready);
endinterface

interface node_if;
    logic                       valid;
    logic                       ready;
    logic [nnt_pkg::NODE_W-1:0] node;
    logic                       tour_end;

    modport source (output valid, output node, output tour_end, input ready);
    modport sink (input valid, input node, input tour_end, output ready);
endinterface
`default_nettype wire

// File: hdl/nnt_cell.sv
// One point of the tour chain: coordinates, visited flag, distance accumulator
// and one stage of the minimum-search chain. Depends on nnt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nnt_cell #(
    parameter int MAX_DIMS = nnt_pkg::MAX_DIMS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  nnt_pkg::cell_ctrl_t                       ctrl,
    input  logic [nnt_pkg::NODE_W-1:0]                idx,
    input  logic signed [nnt_pkg::COORD_W-1:0]        ref_coord,
    output logic signed [nnt_pkg::COORD_W-1:0]        head,
    input  logic [2*nnt_pkg::COORD_W+$clog2(MAX_DIMS):0] dist_in,
    input  logic [nnt_pkg::NODE_W-1:0]                node_in,
    output logic [2*nnt_pkg::COORD_W+$clog2(MAX_DIMS):0] dist_out,
    output logic [nnt_pkg::NODE_W-1:0]                node_out
);
    import nnt_pkg::*;

    localparam int DIST_W = 2*COORD_W + $clog2(MAX_DIMS) + 1;

    logic signed [COORD_W-1:0]   coord_reg [MAX_DIMS];
    logic signed [COORD_W-1:0]   coord_next [MAX_DIMS];
    logic signed [COORD_W-1:0]   head_dly_reg;
    logic signed [COORD_W:0]     diff;
    logic signed [2*COORD_W+1:0] prod;
    logic [2*COORD_W-1:0]        sq_reg;
    logic [DIST_W-1:0]           acc_reg;
    logic [DIST_W-1:0]           acc_next;
    logic                        visited_reg;
    logic                        visited_next;
    logic                        cand;
    logic [DIST_W-1:0]           dist_out_reg;
    logic [NODE_W-1:0]           node_out_reg;
    logic                        wr_hit;

    assign wr_hit = ctrl.wr_en && (ctrl.wr_pt == idx);
    assign head   = coord_reg[0];

    for (genvar k = 0; k < MAX_DIMS; k++) begin : g_coord
        localparam int KN = (k + 1) % MAX_DIMS;
        always_comb
        begin
            coord_next[k] = coord_reg[k];
            if (wr_hit && ctrl.wr_dim == DIMS_W'(k))
            begin
                coord_next[k] = ctrl.wr_data;
            end
            else if (ctrl.rot && DIMS_W'(k) < ctrl.dims)
            begin
                if (DIMS_W'(k) + DIMS_W'(1) == ctrl.dims)
                begin
                    coord_next[k] = coord_reg[0];
                end
                else
                begin
                    coord_next[k] = coord_reg[KN];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            coord_reg[k] <= coord_next[k];
        end
    end

    assign diff = {head_dly_reg[COORD_W-1], head_dly_reg} - {ref_coord[COORD_W-1], ref_coord};
    assign prod = diff * diff;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.acc_clr)
        begin
            acc_next = '0;
        end
        else if (ctrl.acc_en)
        begin
            acc_next = acc_reg + DIST_W'(sq_reg);
        end
    end

    always_comb
    begin
        visited_next = visited_reg;
        if (ctrl.vis_init)
        begin
            visited_next = (idx == '0);
        end
        else if (ctrl.vis_set && ctrl.sel_node == idx)
        begin
            visited_next = 1'b1;
        end
    end

    assign cand = (idx < ctrl.n_pts) && !visited_reg;

    always_ff @(posedge clk)
    begin
        head_dly_reg <= head;
        sq_reg       <= prod[2*COORD_W-1:0];
        acc_reg      <= acc_next;
        if (cand && acc_reg < dist_in)
        begin
            dist_out_reg <= acc_reg;
            node_out_reg <= idx;
        end
        else
        begin
            dist_out_reg <= dist_in;
            node_out_reg <= node_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= 1'b0;
        end
        else
        begin
            visited_reg <= visited_next;
        end
    end

    assign dist_out = dist_out_reg;
    assign node_out = node_out_reg;

endmodule
`default_nettype wire

// File: hdl/nearest_neighbor_tour.sv
// Top level of the nearest-neighbor tour builder: load store, sequencer, cell chain.
// Depends on nnt_pkg, nnt_if (coord_if, node_if) and nnt_cell.
//
// Usage:
//   pts_in carries one coordinate per beat, point-major, dims coordinates per
//   point; the beat with last set closes the load. tour_out then delivers n+1
//   node beats: node 0, the greedy visiting order, and a closing node 0 with
//   tour_end set. cfg_we/cfg_wdata set dims while the block is idle.
// Timing:
//   Loading accepts one coordinate per cycle. After last, the coordinates move
//   from the load memory into the cell row. For each further node, every cell
//   accumulates its squared differences, the minimum then ripples down the cell
//   chain, and the node is emitted. pts_in is not ready from last until the
//   closing beat is registered; the next load may start while that beat still
//   waits.
// Reset:
//   Asynchronous, active low; clears the load count, sequencer and output
//   valid, and sets dims to 2. Load memory contents are not cleared.
// Stall:
//   tour_out holds its beat while ready is low; a new beat waits in the sequencer.
`timescale 1ns / 1ps
`default_nettype none
module nearest_neighbor_tour #(
    parameter int MAX_POINTS = nnt_pkg::MAX_POINTS_DEF,
    parameter int MAX_DIMS   = nnt_pkg::MAX_DIMS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [nnt_pkg::DIMS_W-1:0] cfg_wdata,
    coord_if.sink                      pts_in,
    node_if.source                     tour_out
);
    import nnt_pkg::*;

    localparam int DIST_W      = 2*COORD_W + $clog2(MAX_DIMS) + 1;
    localparam int STORE_DEPTH = MAX_POINTS * MAX_DIMS;
    localparam int AW          = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW          = $clog2(STORE_DEPTH + 1);
    localparam logic [NODE_W-1:0] MAXP   = NODE_W'(MAX_POINTS);
    localparam logic [DIMS_W:0]   MAXD   = (DIMS_W+1)'(MAX_DIMS);

    logic signed [COORD_W-1:0] store_mem [STORE_DEPTH];

    nnt_state_t          state_reg, state_next;
    logic [DIMS_W-1:0]   dims_reg;
    logic [DIMS_W-1:0]   d_eff;
    logic [CW-1:0]       cap;
    logic [CW-1:0]       load_cnt_reg, load_cnt_next;
    logic [CW-1:0]       xa_reg, xa_next;
    logic [NODE_W-1:0]   xpt_reg, xpt_next;
    logic [DIMS_W-1:0]   xdim_reg, xdim_next;
    logic [NODE_W-1:0]   n_reg, n_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   emitted_reg, emitted_next;
    logic [NODE_W-1:0]   cnt_reg, cnt_next;
    logic                wr_en_reg, wr_en_next;
    logic [NODE_W-1:0]   wr_pt_reg, wr_pt_next;
    logic [DIMS_W-1:0]   wr_dim_reg, wr_dim_next;
    logic                wr_zero_reg, wr_zero_next;
    logic signed [COORD_W-1:0] rd_data_reg;
    logic signed [COORD_W-1:0] ref_reg, ref_next;
    logic                mem_we;
    logic                out_valid_reg;
    logic [NODE_W-1:0]   out_node_reg;
    logic                out_end_reg;
    logic                out_free;
    logic                out_load;
    logic [NODE_W-1:0]   out_node_new;
    logic                out_end_new;
    cell_ctrl_t          ctrl;

    logic signed [COORD_W-1:0] heads [MAX_POINTS];
    logic [DIST_W-1:0]         chain_dist [MAX_POINTS+1];
    logic [NODE_W-1:0]         chain_node [MAX_POINTS+1];
    logic [NODE_W-1:0]         winner;

    assign d_eff = (dims_reg == '0) ? DIMS_W'(1) :
                   (({1'b0, dims_reg} > MAXD) ? MAXD[DIMS_W-1:0] : dims_reg);
    assign cap   = CW'(MAX_POINTS) * CW'(d_eff);

    assign out_free = !out_valid_reg || tour_out.ready;
    assign winner   = chain_node[MAX_POINTS];

    assign pts_in.ready    = (state_reg == ST_LOAD);
    assign tour_out.valid    = out_valid_reg;
    assign tour_out.node     = out_node_reg;
    assign tour_out.tour_end = out_end_reg;

    always_comb
    begin
        ref_next = heads[0];
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            if (cur_reg == NODE_W'(i))
            begin
                ref_next = heads[i];
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        xa_next       = xa_reg;
        xpt_next      = xpt_reg;
        xdim_next     = xdim_reg;
        n_next        = n_reg;
        cur_next      = cur_reg;
        emitted_next  = emitted_reg;
        cnt_next      = cnt_reg;
        wr_en_next    = 1'b0;
        wr_pt_next    = xpt_reg;
        wr_dim_next   = xdim_reg;
        wr_zero_next  = wr_zero_reg;
        mem_we        = 1'b0;
        out_load      = 1'b0;
        out_node_new  = '0;
        out_end_new   = 1'b0;

        ctrl          = '0;
        ctrl.wr_en    = wr_en_reg;
        ctrl.wr_pt    = wr_pt_reg;
        ctrl.wr_dim   = wr_dim_reg;
        ctrl.wr_data  = wr_zero_reg ? '0 : rd_data_reg;
        ctrl.sel_node = winner;
        ctrl.n_pts    = n_reg;
        ctrl.dims     = d_eff;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (pts_in.valid)
                begin
                    if (load_cnt_reg < cap)
                    begin
                        mem_we        = 1'b1;
                        load_cnt_next = load_cnt_reg + CW'(1);
                    end
                    if (pts_in.last)
                    begin
                        state_next = ST_XFER;
                        xa_next    = '0;
                        xpt_next   = '0;
                        xdim_next  = '0;
                    end
                end
            end
            ST_XFER:
            begin
                if ((xa_reg >= load_cnt_reg && xdim_reg == '0) || xpt_reg == MAXP)
                begin
                    n_next        = xpt_reg;
                    cur_next      = '0;
                    ctrl.vis_init = 1'b1;
                    state_next    = ST_START;
                end
                else
                begin
                    wr_en_next   = 1'b1;
                    wr_zero_next = (xa_reg >= load_cnt_reg);
                    xa_next      = xa_reg + CW'(1);
                    if (xdim_reg + DIMS_W'(1) == d_eff)
                    begin
                        xdim_next = '0;
                        xpt_next  = xpt_reg + NODE_W'(1);
                    end
                    else
                    begin
                        xdim_next = xdim_reg + DIMS_W'(1);
                    end
                end
            end
            ST_START:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    emitted_next = NODE_W'(1);
                    cnt_next     = '0;
                    state_next   = (n_reg == NODE_W'(1)) ? ST_END : ST_ACC;
                end
            end
            ST_ACC:
            begin
                ctrl.rot     = (cnt_reg < NODE_W'(d_eff));
                ctrl.acc_clr = (cnt_reg == '0);
                ctrl.acc_en  = (cnt_reg >= NODE_W'(2));
                if (cnt_reg == NODE_W'(d_eff) + NODE_W'(1))
                begin
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cnt_next = cnt_reg + NODE_W'(1);
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == MAXP - NODE_W'(1))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + NODE_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_load     = 1'b1;
                    out_node_new = winner;
                    ctrl.vis_set = 1'b1;
                    cur_next     = winner;
                    emitted_next = emitted_reg + NODE_W'(1);
                    cnt_next     = '0;
                    state_next   = (emitted_reg + NODE_W'(1) == n_reg) ? ST_END : ST_ACC;
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_end_new   = 1'b1;
                    load_cnt_next = '0;
                    state_next    = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[load_cnt_reg[AW-1:0]] <= pts_in.coord;
        end
        rd_data_reg <= store_mem[xa_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        xa_reg       <= xa_next;
        xpt_reg      <= xpt_next;
        xdim_reg     <= xdim_next;
        n_reg        <= n_next;
        cur_reg      <= cur_next;
        emitted_reg  <= emitted_next;
        cnt_reg      <= cnt_next;
        wr_pt_reg    <= wr_pt_next;
        wr_dim_reg   <= wr_dim_next;
        wr_zero_reg  <= wr_zero_next;
        ref_reg      <= ref_next;
        if (out_load)
        begin
            out_node_reg <= out_node_new;
            out_end_reg  <= out_end_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            dims_reg      <= DIMS_RESET;
            load_cnt_reg  <= '0;
            wr_en_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            wr_en_reg    <= wr_en_next;
            if (cfg_we)
            begin
                dims_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tour_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign chain_dist[0] = '1;
    assign chain_node[0] = '0;

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        nnt_cell #(
            .MAX_DIMS (MAX_DIMS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .idx       (NODE_W'(i)),
            .ref_coord (ref_reg),
            .head      (heads[i]),
            .dist_in   (chain_dist[i]),
            .node_in   (chain_node[i]),
            .dist_out  (chain_dist[i+1]),
            .node_out  (chain_node[i+1])
        );
    end

endmodule
`default_nettype wire

// File: hdl/nnt_checker.sv
// Port-level checks for nearest_neighbor_tour, attached by bind.
// Depends on nnt_pkg and the top level's port list.
`timescale 1ns / 1ps
`default_nettype none
module nnt_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_last,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [nnt_pkg::NODE_W-1:0] out_node,
    input logic                       out_end
);
    import nnt_pkg::*;

    // hold a stalled beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_node) && $stable(out_end))
        else $error("tour_out beat changed while stalled");

    a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_end |-> out_node == '0)
        else $error("closing beat is not node 0");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input taken right after last beat");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid straight out of reset");

endmodule

bind nearest_neighbor_tour nnt_checker u_nnt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pts_in.valid),
    .in_ready  (pts_in.ready),
    .in_last   (pts_in.last),
    .out_valid (tour_out.valid),
    .out_ready (tour_out.ready),
    .out_node  (tour_out.node),
    .out_end   (tour_out.tour_end)
);
`default_nettype wire
